/* src/frame_quarter_turn_rotator_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quarter-turn rotator.
// Each checks on the rising clock edge and is off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_QUARTER_TURN_ROTATOR_DEFINES_SVH
`define FRAME_QUARTER_TURN_ROTATOR_DEFINES_SVH

// Same-cycle implication.
`define FQTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FQTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fqtr_pkg.sv */
// ----------------------------------------------------------------------------
// fqtr_pkg
// Shared types and constants of the quarter-turn frame rotator.
// ----------------------------------------------------------------------------
package fqtr_pkg;

  localparam int DIM_W      = 9;   // image_width / image_height registers
  localparam int TURN_W     = 8;   // turn_count register
  localparam int COLOR_W    = 8;
  localparam int PIX_W      = 3 * COLOR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // per-read side info that travels with the memory read
  typedef struct packed {
    logic             is_last;
    logic [DIM_W-1:0] rot_w;
    logic [DIM_W-1:0] rot_h;
  } rd_info_t;

endpackage

/* src/fqtr_ram.sv */
// ----------------------------------------------------------------------------
// fqtr_ram
// Generic single-port RAM, one access per cycle, registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module fqtr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/fqtr_addr_gen.sv */
// ----------------------------------------------------------------------------
// fqtr_addr_gen
// Configuration registers, write index and rotated read position.
// Produces the frame store address for each transaction and advances
// the counters when it is accepted.
// ----------------------------------------------------------------------------
module fqtr_addr_gen #(
  parameter int MAX_SIDE   = 256,
  parameter int MAX_PIXELS = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fqtr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fqtr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              acc,
  input  logic                              op,
  output logic [$clog2(MAX_PIXELS)-1:0]     mem_addr,
  output fqtr_pkg::rd_info_t                info
);

  import fqtr_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PIXELS);
  localparam int FULL_W = 2 * DIM_W;
  localparam int POS_W  = ($clog2(MAX_SIDE) < DIM_W) ? $clog2(MAX_SIDE) : DIM_W;
  localparam logic [DIM_W-1:0] SIDE_CAP =
    (MAX_SIDE >= (1 << DIM_W)) ? {DIM_W{1'b1}} : DIM_W'(MAX_SIDE);

  logic [DIM_W-1:0]  width_r, height_r;
  logic              dir_r;
  logic [TURN_W-1:0] count_r;
  logic [FULL_W-1:0] widx_r, widx_nxt;
  logic [POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;

  logic [DIM_W-1:0]  w, h, rot_w, rot_h;
  logic [1:0]        q;
  logic [FULL_W-1:0] total, widx_cur, widx_inc, addr_full;
  logic              stale;
  logic [DIM_W-1:0]  rd, cd, sr, sc, c_inc, r_inc;
  logic [FULL_W-1:0] sel_addr;
  logic [ADDR_W+FULL_W-1:0] addr_ext;

  // 0 -> 1, above the cap -> cap
  function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > SIDE_CAP) begin
      res = SIDE_CAP;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      dir_r    <= 1'b0;
      count_r  <= TURN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_DIR:    dir_r    <= cfg_data[0];
        REG_COUNT:  count_r  <= cfg_data[TURN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    w = clamp_side(width_r);
    h = clamp_side(height_r);
    // left turn n times == right turn 3n times
    q = dir_r ? 2'(count_r[1:0] * 2'd3) : count_r[1:0];
    rot_w = q[0] ? h : w;
    rot_h = q[0] ? w : h;
    total = {{DIM_W{1'b0}}, w} * {{DIM_W{1'b0}}, h};

    // write side
    widx_cur = (widx_r >= total) ? '0 : widx_r;
    widx_inc = widx_cur + FULL_W'(1);
    widx_nxt = (widx_inc >= total) ? '0 : widx_inc;

    // read side, restart if a config change left us outside the image
    stale = (DIM_W'(row_r) >= rot_h) || (DIM_W'(col_r) >= rot_w);
    rd = stale ? '0 : DIM_W'(row_r);
    cd = stale ? '0 : DIM_W'(col_r);
    case (q)
      2'd0: begin
        sr = rd;
        sc = cd;
      end
      2'd1: begin
        sr = cd;
        sc = w - DIM_W'(1) - rd;
      end
      2'd2: begin
        sr = h - DIM_W'(1) - rd;
        sc = w - DIM_W'(1) - cd;
      end
      default: begin
        sr = h - DIM_W'(1) - cd;
        sc = rd;
      end
    endcase
    addr_full = {{DIM_W{1'b0}}, sr} * {{DIM_W{1'b0}}, w} + {{DIM_W{1'b0}}, sc};

    c_inc = cd + DIM_W'(1);
    r_inc = rd + DIM_W'(1);
    if (c_inc >= rot_w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= rot_h) ? '0 : r_inc[POS_W-1:0];
    end else begin
      col_nxt = c_inc[POS_W-1:0];
      row_nxt = rd[POS_W-1:0];
    end

    // store address modulo a power-of-two depth
    sel_addr = (op == OP_READ) ? addr_full : widx_cur;
    addr_ext = {{ADDR_W{1'b0}}, sel_addr};
    mem_addr = addr_ext[ADDR_W-1:0];

    info.is_last = (rd == rot_h - DIM_W'(1)) && (cd == rot_w - DIM_W'(1));
    info.rot_w   = rot_w;
    info.rot_h   = rot_h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (acc) begin
      if (op == OP_READ) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end else begin
        widx_r <= widx_nxt;
      end
    end
  end

endmodule

/* src/frame_quarter_turn_rotator.sv */
// ----------------------------------------------------------------------------
// frame_quarter_turn_rotator
// Frame buffer that stores RGB pixels in row-major order and reads them
// back rotated by a configurable number of quarter turns.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------
//   in      | in  | in_valid/in_ready    | op, red/green/blue pixel
//   out     | out | out_valid/out_ready  | pixel, is_last, rotated dims
//   cfg     | in  | cfg_wr_en            | cfg_index, cfg_data
//
// One transaction per cycle while in_ready is high. Writes give no result. A
// read takes its RAM address at the accepting edge; its data then enters the
// output register when that register is free or being emptied.
// Reset clears counters and pipeline valids; the frame store keeps no reset.
// in_ready drops only while a read sits in the RAM stage behind a stalled
// output register.
// MAX_PIXELS must be a power of two; the block does not check it.
// ----------------------------------------------------------------------------
module frame_quarter_turn_rotator #(
  parameter int MAX_SIDE   = 256,
  parameter int MAX_PIXELS = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [fqtr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fqtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [fqtr_pkg::COLOR_W-1:0]     in_red_in,
  input  logic [fqtr_pkg::COLOR_W-1:0]     in_green_in,
  input  logic [fqtr_pkg::COLOR_W-1:0]     in_blue_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fqtr_pkg::COLOR_W-1:0]     out_red_out,
  output logic [fqtr_pkg::COLOR_W-1:0]     out_green_out,
  output logic [fqtr_pkg::COLOR_W-1:0]     out_blue_out,
  output logic                             out_is_last,
  output logic [fqtr_pkg::DIM_W-1:0]       out_rotated_width,
  output logic [fqtr_pkg::DIM_W-1:0]       out_rotated_height
);

  import fqtr_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PIXELS);

  logic              acc, rd_issue, wr_issue, p1_adv;
  logic [ADDR_W-1:0] mem_addr;
  rd_info_t          cur_info;
  logic [PIX_W-1:0]  rdata;

  logic              p1_valid_r, p1_valid_nxt;
  rd_info_t          p1_info_r;
  logic              out_valid_r, out_valid_nxt;
  rd_info_t          out_info_r;
  logic [PIX_W-1:0]  out_pix_r;

  assign acc      = in_valid && in_ready;
  assign rd_issue = acc && (in_op == OP_READ);
  assign wr_issue = acc && (in_op == OP_WRITE);
  assign p1_adv   = p1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !p1_valid_r || !out_valid_r || out_ready;

  fqtr_addr_gen #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_addr_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .op        (in_op),
    .mem_addr  (mem_addr),
    .info      (cur_info)
  );

  // a write lands before a read issued in the following cycle samples it
  fqtr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wr_issue),
    .re    (rd_issue),
    .addr  (mem_addr),
    .wdata ({in_blue_in, in_green_in, in_red_in}),
    .rdata (rdata)
  );

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (rd_issue) begin
      p1_valid_nxt = 1'b1;
    end else if (p1_adv) begin
      p1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (p1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      p1_info_r <= cur_info;
    end
    if (p1_adv) begin
      out_info_r <= p1_info_r;
      out_pix_r  <= rdata;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_out        = out_pix_r[COLOR_W-1:0];
  assign out_green_out      = out_pix_r[2*COLOR_W-1:COLOR_W];
  assign out_blue_out       = out_pix_r[3*COLOR_W-1:2*COLOR_W];
  assign out_is_last        = out_info_r.is_last;
  assign out_rotated_width  = out_info_r.rot_w;
  assign out_rotated_height = out_info_r.rot_h;

endmodule

/* src/fqtr_checker.sv */
// ----------------------------------------------------------------------------
// fqtr_checker
// Port-level checks of the quarter-turn rotator, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_quarter_turn_rotator_defines.svh"

module fqtr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_op,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [fqtr_pkg::COLOR_W-1:0]    out_red_out,
  input logic [fqtr_pkg::COLOR_W-1:0]    out_green_out,
  input logic [fqtr_pkg::COLOR_W-1:0]    out_blue_out,
  input logic                            out_is_last,
  input logic [fqtr_pkg::DIM_W-1:0]      out_rotated_width,
  input logic [fqtr_pkg::DIM_W-1:0]      out_rotated_height
);

  import fqtr_pkg::*;

  logic rd_acc;
  assign rd_acc = in_valid && in_ready && (in_op == OP_READ);

  `FQTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_red_out) && $stable(out_green_out) &&
    $stable(out_blue_out) && $stable(out_is_last),
    "result changed while stalled")

  `FQTR_ASSERT_NOW(a_dims_nonzero, out_valid,
    (out_rotated_width != '0) && (out_rotated_height != '0),
    "rotated dimension is zero")

  `FQTR_ASSERT_NOW(a_ready_only_on_stall, !in_ready,
    out_valid && !out_ready, "input stalled without output backpressure")

  // a result needs an earlier read transaction, checked through rd_acc and its past value
  `FQTR_ASSERT_NEXT(a_no_spurious_result, !out_valid && !rd_acc && $past(!rd_acc),
    !out_valid, "result without a read transaction")

endmodule

bind frame_quarter_turn_rotator fqtr_checker u_fqtr_checker (.*);
